// ----- src/rtia_pkg.sv -----
`timescale 1ns / 1ps
package rtia_pkg;

  localparam int DefMaxRegions = 256;
  localparam int DefPosBits    = 32;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_CHANGE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_OUTSIDE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIND_RD,
    S_FIND,
    S_UPD_RD,
    S_UPD,
    S_READ_RD,
    S_READ_WAIT,
    S_DONE
  } state_t;

  // classification of one region against a deletion span
  typedef enum logic [2:0] {
    CL_ERASE,
    CL_INSIDE,
    CL_BEFORE,
    CL_AFTER,
    CL_HEAD,
    CL_TAIL
  } class_t;

endpackage

// ----- src/rtia_alu.sv -----
`timescale 1ns / 1ps
// shared region update unit: one region per use
module rtia_alu
  import rtia_pkg::*;
#(
  parameter int PosBits = DefPosBits
) (
  input  logic               del,
  input  logic [PosBits-1:0] ds,
  input  logic [PosBits-1:0] de,
  input  logic [PosBits-1:0] mag,
  input  logic [PosBits-1:0] s,
  input  logic [PosBits-1:0] e,
  output logic [PosBits-1:0] s_new,
  output logic [PosBits-1:0] e_new,
  output logic               erase
);

  logic [PosBits:0]   s_add;
  logic [PosBits:0]   e_add;
  logic [PosBits-1:0] s_sub;
  logic [PosBits-1:0] e_sub;
  class_t             cl;

  assign s_add = {1'b0, s} + {1'b0, mag};
  assign e_add = {1'b0, e} + {1'b0, mag};
  assign s_sub = (s > mag) ? (s - mag) : '0;
  assign e_sub = (e > mag) ? (e - mag) : '0;

  // classify the region against the deletion span
  always_comb begin
    if (ds <= s && de >= e)      cl = CL_ERASE;
    else if (ds >= s && de <= e) cl = CL_INSIDE;
    else if (ds > e)             cl = CL_BEFORE;
    else if (de < s)             cl = CL_AFTER;
    else if (ds < s)             cl = CL_HEAD;
    else                         cl = CL_TAIL;
  end

  always_comb begin
    s_new = s;
    e_new = e;
    erase = 1'b0;
    if (!del) begin
      s_new = s_add[PosBits] ? '1 : s_add[PosBits-1:0];
      e_new = e_add[PosBits] ? '1 : e_add[PosBits-1:0];
    end else begin
      case (cl)
        CL_ERASE:  erase = 1'b1;
        CL_INSIDE: e_new = e_sub;
        CL_AFTER: begin
          s_new = s_sub;
          e_new = e_sub;
        end
        CL_HEAD: begin
          s_new = ds;
          e_new = e_sub;
        end
        CL_TAIL:   e_new = (ds > 0) ? ds - 1'b1 : '0;
        default: ;
      endcase
    end
  end

endmodule

// ----- src/region_table_indel_adjust.sv -----
`timescale 1ns / 1ps
// Region table with insertion and deletion adjustment. Each request word
// (append a region, apply a size change at a position, or read one entry)
// yields exactly one result word. One memory port and one shared update
// unit do all the work. A size change at a position below the sequence
// length walks the table from the first entry to the first region that
// ends at or after the position, then reads every region from there to the
// end and rewrites it, or, for a deletion, rewrites only the survivors,
// compacted. The block takes no new word until the result word has been
// accepted, so a receiver stall also holds off the next request.
module region_table_indel_adjust
  import rtia_pkg::*;
#(
  parameter int MaxRegions = DefMaxRegions,
  parameter int PosBits    = DefPosBits
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // req_type[1:0], position[33:2], size_delta[65:34], load_start[97:66],
  // load_end[129:98], entry_index[137:130], zero fill to 144
  input  logic [143:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[1:0], region_count[10:2], sequence_length[42:11],
  // read_start[74:43], read_end[106:75], zero fill to 112
  output logic [111:0] m_tdata
);

  localparam int IdxBits = $clog2(MaxRegions);
  localparam int CntBits = $clog2(MaxRegions + 1);
  localparam int WBits   = (PosBits > 32) ? PosBits : 32;

  logic [PosBits-1:0] mem_s [MaxRegions];
  logic [PosBits-1:0] mem_e [MaxRegions];

  state_t state, state_next;
  logic [CntBits-1:0] count;
  logic [PosBits-1:0] total;
  logic [CntBits-1:0] rd_i;
  logic [CntBits-1:0] keep;
  logic               first;
  logic [PosBits-1:0] rd_s, rd_e;
  logic [PosBits-1:0] ds, de, mag;
  logic               del;
  req_t               req;
  logic [31:0]        pos_in, size_in, ls_in, le_in;
  logic [7:0]         ei_in;
  status_t            status;
  logic [PosBits-1:0] out_s, out_e;

  logic [PosBits-1:0] a_s, a_e;
  logic               a_erase;

  logic [PosBits-1:0] pos_w, ls_w, le_w;
  logic [31:0]        neg_mag;
  logic [PosBits-1:0] room;
  logic [PosBits-1:0] del_mag, ins_mag;
  logic [PosBits:0]   tot_sum;
  logic [CntBits-1:0] rd_i_inc;
  logic               last;
  logic               read_bad;

  assign pos_w   = PosBits'(pos_in);
  assign ls_w    = PosBits'(ls_in);
  assign le_w    = PosBits'(le_in);
  // deletion span clipped at the sequence end
  assign neg_mag = 32'd0 - size_in;
  assign room    = total - pos_w;
  assign del_mag = (WBits'(neg_mag) > WBits'(room)) ? room : PosBits'(neg_mag);
  // insertion size saturated at the largest position value
  assign ins_mag = (WBits'(size_in) > WBits'({PosBits{1'b1}})) ? '1
                                                               : PosBits'(size_in);
  assign tot_sum  = {1'b0, total} + {1'b0, mag};
  assign rd_i_inc = rd_i + 1'b1;
  assign last     = (rd_i_inc >= count);
  assign read_bad = (32'(ei_in) >= 32'(count));

  rtia_alu #(.PosBits(PosBits)) u_alu (
    .del(del), .ds(ds), .de(de), .mag(mag),
    .s(rd_s), .e(rd_e),
    .s_new(a_s), .e_new(a_e), .erase(a_erase)
  );

  // memory read and write
  logic               we;
  logic [PosBits-1:0] wd_s, wd_e;
  logic [IdxBits-1:0] wa;
  always_ff @(posedge clk) begin
    rd_s <= mem_s[rd_i[IdxBits-1:0]];
    rd_e <= mem_e[rd_i[IdxBits-1:0]];
    if (we) begin
      mem_s[wa] <= wd_s;
      mem_e[wa] <= wd_e;
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_DONE);
  assign m_tdata  = {5'd0, 32'(out_e), 32'(out_s), 32'(total), 9'(count), status};

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    we   = 1'b0;
    wa   = rd_i[IdxBits-1:0];
    wd_s = a_s;
    wd_e = a_e;
    unique case (state)
      S_IDLE: if (s_tvalid) state_next = S_DISPATCH;
      // dispatch after capture
      S_DISPATCH: begin
        unique case (req)
          REQ_APPEND: begin
            state_next = S_DONE;
            if (count < CntBits'(MaxRegions)) begin
              we = 1'b1; wa = count[IdxBits-1:0]; wd_s = ls_w; wd_e = le_w;
            end
          end
          REQ_CHANGE: begin
            if (size_in == '0 || pos_w >= total) state_next = S_DONE;
            else state_next = S_FIND_RD;
          end
          REQ_READ: state_next = read_bad ? S_DONE : S_READ_RD;
          default:  state_next = S_DONE;
        endcase
      end
      // search for first region ending at or after position
      S_FIND_RD: state_next = (rd_i >= count) ? S_DONE : S_FIND;
      S_FIND:    state_next = (rd_e >= ds) ? S_UPD : S_FIND_RD;
      S_UPD_RD:  state_next = S_UPD;
      // update one region, compacting survivors of a deletion
      S_UPD: begin
        state_next = last ? S_DONE : S_UPD_RD;
        if (!del) begin
          we = 1'b1;
          if (first) wd_s = rd_s;
        end else if (!a_erase) begin
          we = 1'b1;
          wa = keep[IdxBits-1:0];
        end
      end
      S_READ_RD:   state_next = S_READ_WAIT;
      S_READ_WAIT: state_next = S_DONE;
      S_DONE:      if (m_tready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (s_tvalid) begin
          req     <= req_t'(s_tdata[1:0]);
          pos_in  <= s_tdata[33:2];
          size_in <= s_tdata[65:34];
          ls_in   <= s_tdata[97:66];
          le_in   <= s_tdata[129:98];
          ei_in   <= s_tdata[137:130];
          status  <= ST_OK;
          out_s   <= '0;
          out_e   <= '0;
        end
        S_DISPATCH: begin
          del   <= size_in[31];
          ds    <= pos_w;
          first <= 1'b1;
          unique case (req)
            REQ_APPEND: begin
              if (count < CntBits'(MaxRegions)) begin
                count <= count + 1'b1;
                total <= (le_w == '1) ? le_w : le_w + 1'b1;
              end else status <= ST_FULL;
            end
            REQ_CHANGE: begin
              if (size_in != '0 && pos_w >= total) status <= ST_OUTSIDE;
              if (size_in[31]) begin
                mag <= del_mag;
                de  <= pos_w + del_mag - 1'b1;
              end else begin
                mag <= ins_mag;
                de  <= pos_w;
              end
              rd_i <= '0;
            end
            REQ_READ: begin
              if (read_bad) status <= ST_RANGE;
              else rd_i <= CntBits'(ei_in);
            end
            default: ;
          endcase
        end
        S_FIND_RD: if (rd_i >= count) status <= ST_OUTSIDE;
        S_FIND: begin
          if (rd_e >= ds) begin
            // hit: apply length change, then walk from here
            keep <= rd_i;
            if (del) total <= total - mag;
            else total <= tot_sum[PosBits] ? '1 : tot_sum[PosBits-1:0];
          end else begin
            rd_i <= rd_i_inc;
          end
        end
        S_UPD: begin
          first <= 1'b0;
          rd_i  <= rd_i_inc;
          if (del && !a_erase) keep <= keep + 1'b1;
          if (del && last) count <= a_erase ? keep : keep + 1'b1;
        end
        S_READ_WAIT: begin
          out_s <= rd_s;
          out_e <= rd_e;
        end
        default: ;
      endcase
    end
  end

  // a result only appears after a word was taken
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) != S_IDLE)
    else $error("result without request");
  // count never exceeds table depth
  assert property (@(posedge clk) disable iff (rst)
    count <= CntBits'(MaxRegions))
    else $error("count overflow");
  // no new word taken while a result waits
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("overlap");

endmodule
